FILE: hw/rtl/pts_pkg.sv
package pts_pkg;

  localparam int NumTasksDef = 8;
  localparam int JobSlotsDef = 16;
  localparam int TW = 15;
  localparam logic [TW-1:0] Max15 = 15'h7fff;
  localparam logic [TW-1:0] HorizonReset = 15'd500;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_POLICY  = 2'd0,
    CFG_HORIZON = 2'd1,
    CFG_TASKS   = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    POL_RM  = 2'd0,
    POL_DM  = 2'd1,
    POL_EDF = 2'd2,
    POL_ALT = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPLETE,
    ST_RELEASE,
    ST_PICK,
    ST_RUN,
    ST_RESTART,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [2:0]    task_index;
    logic [TW-1:0] task_arrival;
    logic [TW-1:0] task_period;
    logic [TW-1:0] task_deadline;
    logic [TW-1:0] task_exec;
  } in_word_t;

  typedef struct packed {
    logic [TW-1:0] now_time;
    logic [3:0]    running_task;
    logic          finish_valid;
    logic [2:0]    finish_task;
    logic [TW-1:0] finish_job;
    logic          miss_seen;
    logic [TW-1:0] miss_time;
    logic [2:0]    miss_task;
    logic [TW-1:0] busy_units;
    logic          run_over;
    logic          store_overflow;
  } out_word_t;

  // ranking key compare: key, then task, then job number, then slot order
  typedef struct packed {
    logic [16:0]   key;
    logic [4:0]    tsk;
    logic [TW-1:0] job;
  } rank_t;

endpackage

FILE: hw/rtl/pts_rank_cmp.sv
module pts_rank_cmp (
  input  pts_pkg::rank_t cand,
  input  pts_pkg::rank_t best,
  input  logic           have,
  output logic           take
);
  import pts_pkg::*;

  // strictly better wins; equal keeps the earlier slot
  always_comb begin
    take = !have || (cand < best);
  end

endmodule

FILE: hw/rtl/periodic_task_scheduler_unit.sv
// out_valid is set in ST_DONE: a load word goes there straight, a restart word via ST_RESTART,
// a tick past the horizon via ST_COMPLETE, and any other tick via ST_COMPLETE, ST_RELEASE,
// ST_PICK and ST_RUN; ST_RELEASE sweeps the JOB_SLOTS slots for each due task, and the pick
// is one more sweep through one shared ranking comparator
// one word in flight; the next word is taken the cycle after the result is accepted
// rst clears control state, all jobs and pending releases; task table entries stay undefined
module periodic_task_scheduler_unit #(
  parameter int NUM_TASKS = pts_pkg::NumTasksDef,
  parameter int JOB_SLOTS = pts_pkg::JobSlotsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pts_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pts_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import pts_pkg::*;

  localparam int TIW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int SW  = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int TCW = $clog2(NUM_TASKS + 1);

  // configuration
  logic [1:0]    policy;
  logic [TW-1:0] horizon;
  logic [3:0]    task_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POL_RM;
      horizon    <= HorizonReset;
      task_count <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POLICY:  policy     <= cfg_data[1:0];
        CFG_HORIZON: horizon    <= cfg_data;
        CFG_TASKS:   task_count <= cfg_data[3:0];
        default:     ;
      endcase
    end
  end

  // task table and per-task release state
  logic [TW-1:0] t_arr [NUM_TASKS];
  logic [TW-1:0] t_per [NUM_TASKS];
  logic [TW-1:0] t_dl  [NUM_TASKS];
  logic [TW-1:0] t_ex  [NUM_TASKS];
  logic          rel_v [NUM_TASKS];
  logic [16:0]   rel_t [NUM_TASKS];
  logic [TW-1:0] jnum  [NUM_TASKS];

  // job store
  logic          j_v   [JOB_SLOTS];
  logic [TIW-1:0] j_tk [JOB_SLOTS];
  logic [TW-1:0] j_no  [JOB_SLOTS];
  logic [16:0]   j_dl  [JOB_SLOTS];
  logic [TW-1:0] j_rem [JOB_SLOTS];

  state_t state, state_next;
  out_word_t res;
  logic [15:0] time_now;
  logic run_v;
  logic [SW-1:0] run_slot;
  logic miss_v, ovf;
  logic [TW-1:0] miss_t, busy;
  logic [2:0] miss_k;
  logic [TCW-1:0] ti;
  logic [SW:0] sp;
  logic found_old, have;
  logic [SW-1:0] best_slot, free_slot;
  logic free_have;
  rank_t best_rank, cand_rank;
  logic take;
  logic [TCW-1:0] n_act;
  logic [TW-1:0] t15;
  logic [TW-1:0] shown_now;

  assign n_act = (32'(task_count) > NUM_TASKS) ? TCW'(NUM_TASKS) : TCW'(task_count);
  assign t15   = time_now[TW-1:0];
  assign shown_now = time_now[15] ? Max15 : t15;
  assign in_ready = (state == ST_IDLE) && !out_valid;

  wire [SW-1:0] spi = sp[SW-1:0];
  wire [TIW-1:0] tii = ti[TIW-1:0];

  // ranking key for the slot under the pointer
  always_comb begin
    case (policy_t'(policy))
      POL_RM:  cand_rank.key = {2'b0, t_per[j_tk[spi]]};
      POL_DM:  cand_rank.key = {2'b0, t_dl[j_tk[spi]]};
      default: cand_rank.key = j_dl[spi];
    endcase
    cand_rank.tsk = 5'(j_tk[spi]);
    cand_rank.job = j_no[spi];
  end

  pts_rank_cmp u_cmp (
    .cand(cand_rank), .best(best_rank), .have(have), .take(take)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (in_valid && in_ready) begin
          if (in_data.cmd == CMD_TICK) state_next = ST_COMPLETE;
          else if (in_data.cmd == CMD_RESTART) state_next = ST_RESTART;
          else state_next = ST_DONE;
        end
      ST_COMPLETE: state_next = (time_now > {1'b0, horizon}) ? ST_DONE : ST_RELEASE;
      ST_RELEASE:  if (ti >= n_act) state_next = ST_PICK;
      ST_PICK:     if (sp == (SW+1)'(JOB_SLOTS)) state_next = ST_RUN;
      ST_RUN:      state_next = ST_DONE;
      ST_RESTART:  state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_data = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      time_now <= '0;
      run_v <= 1'b0;
      miss_v <= 1'b0;
      ovf <= 1'b0;
      busy <= '0;
      miss_t <= '0;
      miss_k <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        rel_v[i] <= 1'b0;
        jnum[i]  <= 15'd1;
      end
      for (int s = 0; s < JOB_SLOTS; s++) j_v[s] <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE:
          if (in_valid && in_ready) begin
            // current time is shown unless the word restarts the run
            res <= '{now_time: ((in_data.cmd == CMD_RESTART) ? {TW{1'b0}} : shown_now),
                     default: '0};
            if (in_data.cmd == CMD_LOAD && 32'(in_data.task_index) < NUM_TASKS) begin
              t_arr[TIW'(in_data.task_index)] <= in_data.task_arrival;
              t_per[TIW'(in_data.task_index)] <= in_data.task_period;
              t_dl[TIW'(in_data.task_index)]  <= in_data.task_deadline;
              t_ex[TIW'(in_data.task_index)]  <= in_data.task_exec;
            end
          end
        ST_COMPLETE: begin
          ti <= '0; sp <= '0; found_old <= 1'b0;
          free_have <= 1'b0; have <= 1'b0;
          if (time_now <= {1'b0, horizon}) begin
            if (run_v && j_v[run_slot] && j_rem[run_slot] == '0) begin
              res.finish_valid <= 1'b1;
              res.finish_task  <= 3'(j_tk[run_slot]);
              res.finish_job   <= j_no[run_slot];
              if ({1'b0, time_now} > j_dl[run_slot] && !miss_v) begin
                miss_v <= 1'b1; miss_t <= t15; miss_k <= 3'(j_tk[run_slot]);
              end
              j_v[run_slot] <= 1'b0;
            end
            run_v <= 1'b0;
          end
        end
        ST_RELEASE:
          if (ti < n_act) begin
            if (!rel_v[tii] || rel_t[tii] != {1'b0, time_now}) begin
              ti <= ti + 1'b1;
            end else if (sp < (SW+1)'(JOB_SLOTS)) begin
              // scan one slot: old job of this task and first free slot
              if (j_v[spi] && j_tk[spi] == tii) found_old <= 1'b1;
              if (!j_v[spi] && !free_have) begin
                free_have <= 1'b1; free_slot <= spi;
              end
              sp <= sp + 1'b1;
            end else begin
              if (found_old && !miss_v) begin
                miss_v <= 1'b1; miss_t <= t15; miss_k <= 3'(tii);
              end
              if (free_have) begin
                j_v[free_slot]   <= 1'b1;
                j_tk[free_slot]  <= tii;
                j_no[free_slot]  <= jnum[tii];
                j_dl[free_slot]  <= 17'(time_now) + 17'(t_dl[tii]);
                j_rem[free_slot] <= (t_ex[tii] == '0) ? 15'd1 : t_ex[tii];
              end else ovf <= 1'b1;
              if (jnum[tii] != Max15) jnum[tii] <= jnum[tii] + 1'b1;
              if (17'(time_now) + 17'((t_per[tii] == '0) ? 15'd1 : t_per[tii])
                  <= 17'(horizon))
                rel_t[tii] <= 17'(time_now) + 17'((t_per[tii] == '0) ? 15'd1 : t_per[tii]);
              else rel_v[tii] <= 1'b0;
              ti <= ti + 1'b1; sp <= '0; found_old <= 1'b0; free_have <= 1'b0;
            end
          end else sp <= '0;
        ST_PICK:
          if (sp < (SW+1)'(JOB_SLOTS)) begin
            if (j_v[spi] && take) begin
              have <= 1'b1; best_slot <= spi; best_rank <= cand_rank;
            end
            sp <= sp + 1'b1;
          end
        ST_RUN: begin
          if (have) begin
            res.running_task <= 4'(j_tk[best_slot]) + 4'd1;
            if (time_now < {1'b0, horizon}) begin
              if (j_rem[best_slot] != '0) j_rem[best_slot] <= j_rem[best_slot] - 1'b1;
              if (busy != Max15) busy <= busy + 1'b1;
              run_v <= 1'b1; run_slot <= best_slot;
            end
          end
          res.now_time <= t15;
          time_now <= time_now + 1'b1;
        end
        ST_RESTART: begin
          time_now <= '0; run_v <= 1'b0; miss_v <= 1'b0; miss_t <= '0;
          miss_k <= '0; busy <= '0; ovf <= 1'b0;
          for (int i = 0; i < NUM_TASKS; i++) begin
            rel_v[i] <= (TCW'(i) < n_act);
            rel_t[i] <= 17'(t_arr[i]);
            jnum[i]  <= 15'd1;
          end
          for (int s = 0; s < JOB_SLOTS; s++) j_v[s] <= 1'b0;
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          res.miss_seen <= miss_v;
          res.miss_time <= miss_t;
          res.miss_task <= miss_k;
          res.busy_units <= busy;
          res.run_over <= time_now > {1'b0, horizon};
          res.store_overflow <= ovf;
        end
        default: ;
      endcase
    end
  end

endmodule
